// File: rtl/dna_pkg.sv
// shared types, constants and saturation helpers for the dual number alu
package dna_pkg;

    localparam int DATA_W   = 32;
    localparam int QBITS    = 33;               // quotient bits below the saturation limit
    localparam int VDIV_W   = 32;               // divisor width of the value lane
    localparam int SDIV_W   = 63;               // divisor width of the slope lane (b_value squared)
    localparam int IN_W     = 136;
    localparam int OUT_W    = 72;

    localparam logic [2:0] CMD_NEG = 3'd0;
    localparam logic [2:0] CMD_ADD = 3'd1;
    localparam logic [2:0] CMD_SUB = 3'd2;
    localparam logic [2:0] CMD_MUL = 3'd3;
    localparam logic [2:0] CMD_DIV = 3'd4;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              ov;
    } t_sat;

    // items travelling beside the divider lanes
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              dz;
        logic [DATA_W-1:0] res_value;
        logic [DATA_W-1:0] res_slope;
        logic              ov;
        logic              neg_v;
        logic              neg_s;
        logic              sat_v;
        logic              sat_s;
    } t_side;

    // clamp a wide signed value to 32 bits
    function automatic t_sat sat49(input logic signed [48:0] x);
        t_sat s;
        if (x > 49'sh0_0000_7FFF_FFFF) begin
            s.val = 32'h7FFF_FFFF;
            s.ov  = 1'b1;
        end else if (x < -49'sh0_0000_8000_0000) begin
            s.val = 32'h8000_0000;
            s.ov  = 1'b1;
        end else begin
            s.val = x[31:0];
            s.ov  = 1'b0;
        end
        return s;
    endfunction

    // apply sign and saturation to a quotient magnitude
    function automatic t_sat fin_div(input logic [QBITS-1:0] q, input logic neg,
                                     input logic sat);
        t_sat              s;
        logic signed [48:0] sq;
        sq = neg ? -$signed({16'b0, q}) : $signed({16'b0, q});
        if (sat) begin
            s.val = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            s.ov  = 1'b1;
        end else begin
            s = sat49(sq);
        end
        return s;
    endfunction

endpackage

// File: rtl/dna_front.sv
// input multipliers and operand preparation, two register stages
module dna_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [2:0]                   i_command,
    input  logic [dna_pkg::DATA_W-1:0]   i_a_value,
    input  logic [dna_pkg::DATA_W-1:0]   i_a_slope,
    input  logic [dna_pkg::DATA_W-1:0]   i_b_value,
    input  logic [dna_pkg::DATA_W-1:0]   i_b_slope,
    output dna_pkg::t_side               o_side,
    output logic [dna_pkg::VDIV_W-1:0]   o_v_top,
    output logic [dna_pkg::VDIV_W-1:0]   o_v_div,
    output logic [dna_pkg::QBITS-1:0]    o_v_rest,
    output logic [dna_pkg::SDIV_W-1:0]   o_s_top,
    output logic [dna_pkg::SDIV_W-1:0]   o_s_div,
    output logic [dna_pkg::QBITS-1:0]    o_s_rest
);
    import dna_pkg::*;

    logic               r_b_valid;
    logic [2:0]         r_b_cmd;
    logic signed [31:0] r_b_av, r_b_as, r_b_bv, r_b_bs;
    logic signed [63:0] r_b_pvv, r_b_pvs, r_b_psv, r_b_pdd;

    logic               n_is_div, n_dz, n_sat_v, n_sat_s, n_neg_s;
    t_sat               n_rv, n_rs;
    logic signed [32:0] sum_v, sum_s;
    logic signed [64:0] prod_sum, diff;
    logic [32:0]        mag_av_w;
    logic [31:0]        mag_av, mag_bv;
    logic [64:0]        nmag_w;
    logic [63:0]        nmag;
    logic [VDIV_W-1:0]  n_v_top;
    logic [SDIV_W-1:0]  n_s_top;

    t_side              r_side;
    logic [VDIV_W-1:0]  r_v_top, r_v_div;
    logic [QBITS-1:0]   r_v_rest, r_s_rest;
    logic [SDIV_W-1:0]  r_s_top, r_s_div;

    // stage b: the four products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= i_valid;
        end
        if (i_en) begin
            r_b_cmd <= i_command;
            r_b_av  <= i_a_value;
            r_b_as  <= i_a_slope;
            r_b_bv  <= i_b_value;
            r_b_bs  <= i_b_slope;
            r_b_pvv <= $signed(i_a_value) * $signed(i_b_value);
            r_b_pvs <= $signed(i_a_value) * $signed(i_b_slope);
            r_b_psv <= $signed(i_a_slope) * $signed(i_b_value);
            r_b_pdd <= $signed(i_b_value) * $signed(i_b_value);
        end
    end

    // stage c: simple results and divider operands
    always_comb begin
        n_is_div = 1'b0;
        n_dz     = 1'b0;
        n_rv     = '0;
        n_rs     = '0;
        sum_v    = '0;
        sum_s    = '0;
        prod_sum = r_b_pvs + r_b_psv;
        case (r_b_cmd)
            CMD_NEG: begin
                sum_v = -{r_b_av[31], r_b_av};
                sum_s = -{r_b_as[31], r_b_as};
                n_rv  = sat49({{16{sum_v[32]}}, sum_v});
                n_rs  = sat49({{16{sum_s[32]}}, sum_s});
            end
            CMD_ADD: begin
                sum_v = {r_b_av[31], r_b_av} + {r_b_bv[31], r_b_bv};
                sum_s = {r_b_as[31], r_b_as} + {r_b_bs[31], r_b_bs};
                n_rv  = sat49({{16{sum_v[32]}}, sum_v});
                n_rs  = sat49({{16{sum_s[32]}}, sum_s});
            end
            CMD_SUB: begin
                sum_v = {r_b_av[31], r_b_av} - {r_b_bv[31], r_b_bv};
                sum_s = {r_b_as[31], r_b_as} - {r_b_bs[31], r_b_bs};
                n_rv  = sat49({{16{sum_v[32]}}, sum_v});
                n_rs  = sat49({{16{sum_s[32]}}, sum_s});
            end
            CMD_MUL: begin
                n_rv = sat49(49'(r_b_pvv >>> 16));
                n_rs = sat49(prod_sum[64:16]);
            end
            CMD_DIV: begin
                if (r_b_bv == 32'sd0) begin
                    n_dz = 1'b1;
                end else begin
                    n_is_div = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // magnitudes, dividends and saturation checks for the divider
    always_comb begin
        mag_av_w = r_b_av[31] ? -{1'b1, r_b_av} : {1'b0, r_b_av};
        mag_av   = mag_av_w[31:0];
        mag_av_w = r_b_bv[31] ? -{1'b1, r_b_bv} : {1'b0, r_b_bv};
        mag_bv   = mag_av_w[31:0];
        mag_av_w = r_b_av[31] ? -{1'b1, r_b_av} : {1'b0, r_b_av};
        diff     = {r_b_psv[63], r_b_psv} - {r_b_pvs[63], r_b_pvs};
        n_neg_s  = diff[64];
        nmag_w   = diff[64] ? -diff : diff;
        nmag     = nmag_w[63:0];
        n_v_top  = {17'b0, mag_av[31:17]};
        n_s_top  = {16'b0, nmag[63:17]};
        n_sat_v  = n_v_top >= mag_bv;
        n_sat_s  = n_s_top >= r_b_pdd[SDIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side.valid <= r_b_valid;
        end
        if (i_en) begin
            r_side.is_div    <= n_is_div;
            r_side.dz        <= n_dz;
            r_side.res_value <= n_rv.val;
            r_side.res_slope <= n_rs.val;
            r_side.ov        <= n_rv.ov | n_rs.ov;
            r_side.neg_v     <= r_b_av[31] ^ r_b_bv[31];
            r_side.neg_s     <= n_neg_s;
            r_side.sat_v     <= n_sat_v;
            r_side.sat_s     <= n_sat_s;
            r_v_top          <= n_v_top;
            r_v_div          <= mag_bv;
            r_v_rest         <= {mag_av[16:0], 16'b0};
            r_s_top          <= n_s_top;
            r_s_div          <= r_b_pdd[SDIV_W-1:0];
            r_s_rest         <= {nmag[16:0], 16'b0};
        end
    end

    assign o_side   = r_side;
    assign o_v_top  = r_v_top;
    assign o_v_div  = r_v_div;
    assign o_v_rest = r_v_rest;
    assign o_s_top  = r_s_top;
    assign o_s_div  = r_s_div;
    assign o_s_rest = r_s_rest;

endmodule

// File: rtl/dna_div_lane.sv
// pipelined restoring divider, one quotient bit per register stage
module dna_div_lane #(
    parameter int W     = dna_pkg::VDIV_W,
    parameter int STEPS = dna_pkg::QBITS
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [W-1:0]     i_top,
    input  logic [W-1:0]     i_div,
    input  logic [STEPS-1:0] i_rest,
    output logic [STEPS-1:0] o_quot
);
    logic [W-1:0]     r_rem  [STEPS];
    logic [W-1:0]     r_div  [STEPS];
    logic [STEPS-1:0] r_rest [STEPS];
    logic [STEPS-1:0] r_quot [STEPS];

    for (genvar gi = 0; gi < STEPS; gi++) begin : g_step
        logic [W-1:0]     rem_in, div_in, n_rem;
        logic [STEPS-1:0] rest_in, quot_in;
        logic [W:0]       shifted;
        logic             qbit;

        if (gi == 0) begin : g_first
            assign rem_in  = i_top;
            assign div_in  = i_div;
            assign rest_in = i_rest;
            assign quot_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[gi-1];
            assign div_in  = r_div[gi-1];
            assign rest_in = r_rest[gi-1];
            assign quot_in = r_quot[gi-1];
        end

        // trial subtract of the divisor from the shifted remainder
        always_comb begin
            shifted = {rem_in, rest_in[STEPS-1]};
            qbit    = shifted >= {1'b0, div_in};
            n_rem   = qbit ? W'(shifted - {1'b0, div_in}) : shifted[W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gi]  <= n_rem;
                r_div[gi]  <= div_in;
                r_rest[gi] <= {rest_in[STEPS-2:0], 1'b0};
                r_quot[gi] <= {quot_in[STEPS-2:0], qbit};
            end
        end
    end

    assign o_quot = r_quot[STEPS-1];

endmodule

// File: rtl/dual_number_alu.sv
// Dual number ALU: negate, add, subtract, multiply and divide on signed Q16.16
// (value, slope) pairs following forward-mode differentiation rules, with
// saturation, an overflow flag and a divide-by-zero flag. Fully pipelined:
// one beat accepted per cycle while the output side is taking beats. The path
// from input beat to output beat runs through the input register, the
// multiplier stage, the preparation stage, 33 divider stages giving one quotient
// bit each and the output register. Every command takes the same path, so results
// leave in order. A stall on the output holds the whole pipeline.
module dual_number_alu (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // command[2:0], a_value[34:3], a_slope[66:35], b_value[98:67], b_slope[130:99]
    input  logic [dna_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_value[31:0], out_slope[63:32], overflow[64], div_by_zero[65]
    output logic [dna_pkg::OUT_W-1:0]   m_axis_tdata
);
    import dna_pkg::*;

    logic              en;
    logic              r_a_valid;
    logic [2:0]        r_a_cmd;
    logic [DATA_W-1:0] r_a_av, r_a_as, r_a_bv, r_a_bs;

    t_side             c_side;
    logic [VDIV_W-1:0] v_top, v_div;
    logic [SDIV_W-1:0] s_top, s_div;
    logic [QBITS-1:0]  v_rest, s_rest, v_quot, s_quot;

    t_side             r_side [QBITS];
    t_sat              fin_v, fin_s;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value, r_out_slope;
    logic              r_out_ov, r_out_dz;

    // pipeline advances while the output slot is free or being taken
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= s_axis_tvalid;
        end
        if (en) begin
            r_a_cmd <= s_axis_tdata[2:0];
            r_a_av  <= s_axis_tdata[34:3];
            r_a_as  <= s_axis_tdata[66:35];
            r_a_bv  <= s_axis_tdata[98:67];
            r_a_bs  <= s_axis_tdata[130:99];
        end
    end

    dna_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_a_valid),
        .i_command (r_a_cmd),
        .i_a_value (r_a_av),
        .i_a_slope (r_a_as),
        .i_b_value (r_a_bv),
        .i_b_slope (r_a_bs),
        .o_side    (c_side),
        .o_v_top   (v_top),
        .o_v_div   (v_div),
        .o_v_rest  (v_rest),
        .o_s_top   (s_top),
        .o_s_div   (s_div),
        .o_s_rest  (s_rest)
    );

    dna_div_lane #(.W(VDIV_W), .STEPS(QBITS)) u_div_value (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_top  (v_top),
        .i_div  (v_div),
        .i_rest (v_rest),
        .o_quot (v_quot)
    );

    dna_div_lane #(.W(SDIV_W), .STEPS(QBITS)) u_div_slope (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_top  (s_top),
        .i_div  (s_div),
        .i_rest (s_rest),
        .o_quot (s_quot)
    );

    // sideband delay line matching the divider depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QBITS; k++) begin
                r_side[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_side[0] <= c_side;
            for (int k = 1; k < QBITS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // sign and saturation of the quotients
    always_comb begin
        fin_v = fin_div(v_quot, r_side[QBITS-1].neg_v, r_side[QBITS-1].sat_v);
        fin_s = fin_div(s_quot, r_side[QBITS-1].neg_s, r_side[QBITS-1].sat_s);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_side[QBITS-1].valid;
        end
        if (en) begin
            r_out_dz <= r_side[QBITS-1].dz;
            if (r_side[QBITS-1].is_div) begin
                r_out_value <= fin_v.val;
                r_out_slope <= fin_s.val;
                r_out_ov    <= fin_v.ov | fin_s.ov;
            end else begin
                r_out_value <= r_side[QBITS-1].res_value;
                r_out_slope <= r_side[QBITS-1].res_slope;
                r_out_ov    <= r_side[QBITS-1].ov;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_dz, r_out_ov, r_out_slope, r_out_value};

endmodule

// File: verif/dna_checker.sv
// checker for the dual number alu: predicts each result beat and compares it
module dna_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [dna_pkg::IN_W-1:0]     i_in_data,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [dna_pkg::OUT_W-1:0]    i_out_data,
    output int                           o_errors,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dna_pkg::*;

    typedef struct packed {
        logic        dz;
        logic        ov;
        logic [31:0] slope;
        logic [31:0] value;
    } t_dual_res;

    t_dual_res expected_q[$];

    // clamp an exact value to 32 bits, noting saturation
    function automatic logic [31:0] clamp32(input logic signed [159:0] x, inout logic ov);
        if (x > 160'sh7FFF_FFFF) begin
            ov = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (x < -160'sh8000_0000) begin
            ov = 1'b1;
            return 32'h8000_0000;
        end
        return x[31:0];
    endfunction

    // truncating division of num*2^16 by den, both exact
    function automatic logic signed [159:0] trunc_div16(input logic signed [159:0] num,
                                                        input logic signed [159:0] den);
        logic signed [159:0] n;
        n = num <<< 16;
        return n / den;
    endfunction

    // forward-mode dual arithmetic
    function automatic t_dual_res dual_result(input logic [IN_W-1:0] d);
        t_dual_res r;
        logic [2:0] cmd;
        logic signed [159:0] av, as, bv, bs;
        cmd = d[2:0];
        av = $signed(d[34:3]);
        as = $signed(d[66:35]);
        bv = $signed(d[98:67]);
        bs = $signed(d[130:99]);
        r = '0;
        case (cmd)
            CMD_NEG: begin
                r.value = clamp32(-av, r.ov);
                r.slope = clamp32(-as, r.ov);
            end
            CMD_ADD: begin
                r.value = clamp32(av + bv, r.ov);
                r.slope = clamp32(as + bs, r.ov);
            end
            CMD_SUB: begin
                r.value = clamp32(av - bv, r.ov);
                r.slope = clamp32(as - bs, r.ov);
            end
            CMD_MUL: begin
                r.value = clamp32((av * bv) >>> 16, r.ov);
                r.slope = clamp32((av * bs + as * bv) >>> 16, r.ov);
            end
            CMD_DIV: begin
                if (bv == 0) begin
                    r.dz = 1'b1;
                end else begin
                    r.value = clamp32(trunc_div16(av, bv), r.ov);
                    r.slope = clamp32(trunc_div16(as * bv - bs * av, bv * bv), r.ov);
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    assign o_pending = expected_q.size();

    // predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        t_dual_res want, got;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                expected_q.push_back(dual_result(i_in_data));
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[65:0];
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.value !== got.value || want.slope !== got.slope ||
                        want.ov !== got.ov || want.dz !== got.dz) begin
                        $display({"%0t: mismatch expected v=%h s=%h ov=%b dz=%b",
                                  " actual v=%h s=%h ov=%b dz=%b"},
                                 $time, want.value, want.slope, want.ov, want.dz,
                                 got.value, got.slope, got.ov, got.dz);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// File: verif/tb_dual_number_alu.sv
// top testbench for the dual number alu: stimulus, flow control and verdict
module tb_dual_number_alu;
    timeunit 1ns;
    timeprecision 1ps;
    import dna_pkg::*;

    localparam int LATENCY = 37;
    localparam int LIMIT   = 400000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [IN_W-1:0]  s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [OUT_W-1:0] m_data;
    int               errors, pending;
    int               send_idle = 0, recv_idle = 0;
    bit               hold_recv = 0;
    int               cycles = 0;

    always #2 i_clk = ~i_clk;

    dual_number_alu dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data)
    );

    dna_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_data(s_data),
        .i_out_valid(m_valid), .i_out_ready(m_ready), .i_out_data(m_data),
        .o_errors(errors), .o_pending(pending)
    );

    // timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_dual_number_alu: errors");
            $finish;
        end
    end

    // receiver ready with random stalls or a long hold-off
    always @(negedge i_clk)
        m_ready <= !hold_recv && ($urandom_range(99) >= recv_idle);

    // random operand with frequent edge values
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
            4: return $signed($urandom_range(16'hFFFF)) - 32'sh8000;
            5: return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // offer one beat and wait for its acceptance
    task automatic send_beat(input logic [2:0] cmd, input logic [31:0] av,
                             input logic [31:0] as, input logic [31:0] bv,
                             input logic [31:0] bs);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_data  <= {5'b0, bs, bv, as, av, cmd};
        s_valid <= 1'b1;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int n);
        logic [2:0] cmd;
        logic [31:0] bv;
        for (int i = 0; i < n; i++) begin
            cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                            : 3'($urandom_range(CMD_DIV));
            bv = pick_operand();
            if (cmd == CMD_DIV && bv == 0 && $urandom_range(3) != 0) bv = $urandom;
            send_beat(cmd, pick_operand(), pick_operand(), bv, pick_operand());
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] edges [4];
        edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: every command at the field extremes, divide by zero, unused codes
        foreach (edges[k]) begin
            send_beat(CMD_NEG, edges[k], edges[3-k], 0, 0);
            send_beat(CMD_MUL, edges[k], edges[k], edges[3-k], edges[k]);
        end
        send_beat(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF);
        send_beat(CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF);
        send_beat(CMD_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0, 32'h5);
        send_beat(CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h7FFF_FFFF);
        send_beat(CMD_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        send_beat(CMD_DIV, 32'hFFFD_0000, 32'h0001_8000, 32'h0002_0000, 32'hFFFF_0000);
        send_beat(CMD_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_beat(3'd5, 32'h1234, 32'h1, 32'h2, 32'h3);
        send_beat(3'd6, 32'hFFFF_FFFF, 32'h1, 32'h2, 32'h3);
        send_beat(3'd7, 32'h8000_0000, 32'h1, 32'h2, 32'h3);
        drain();

        // long receiver hold-off while the sender keeps offering beats
        hold_recv = 1;
        fork
            begin
                repeat (150) @(negedge i_clk);
                hold_recv = 0;
            end
            send_random(100);
        join
        drain();

        send_idle = 13; recv_idle = 83;
        send_random(400);
        drain();
        send_idle = 83; recv_idle = 13;
        send_random(400);
        drain();
        send_idle = 0; recv_idle = 0;
        send_random(400);
        drain();

        repeat (LATENCY + 10) @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("tb_dual_number_alu: clean");
        else
            $display("tb_dual_number_alu: errors");
        $finish;
    end
endmodule

// File: sim.f
rtl/dna_pkg.sv
rtl/dna_front.sv
rtl/dna_div_lane.sv
rtl/dual_number_alu.sv
verif/dna_checker.sv
verif/tb_dual_number_alu.sv
